[rtl/core/gipc_pkg.sv]
package gipc_pkg;

    // Item kinds carried on the input tuser
    typedef enum logic [1:0] {
        KIND_TICK    = 2'd0,
        KIND_FRAME   = 2'd1,
        KIND_EDGE    = 2'd2,
        KIND_COMMAND = 2'd3
    } kind_t;

    // Configuration register indexes
    localparam int unsigned CFG_INDEX_W = 3;
    localparam int unsigned CFG_DATA_W  = 20;

    localparam logic [CFG_INDEX_W-1:0] CFG_MIN_RPM       = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_MAX_RPM       = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_MIN_COOLANT   = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_HOLDOFF_TICKS = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_DURATION_STEP = 3'd4;

    // Frame identifiers
    localparam logic [10:0] ID_ENGINE  = 11'h280;
    localparam logic [10:0] ID_SPEED   = 11'h288;
    localparam logic [10:0] ID_TEMPS   = 11'h420;
    localparam logic [10:0] ID_FUEL    = 11'h320;

    // Command bytes (ASCII digits)
    localparam logic [7:0] CMD_ENABLE  = 8'd49;
    localparam logic [7:0] CMD_DISABLE = 8'd50;
    localparam logic [7:0] CMD_LONGER  = 8'd51;
    localparam logic [7:0] CMD_SHORTER = 8'd52;

    // Counter limits and reset values
    localparam logic [15:0] PULSE_MAX        = 16'hFFFF;
    localparam logic [19:0] HOLDOFF_MAX      = 20'hFFFFF;
    localparam logic [15:0] PULSE_LEN_RESET  = 16'd100;

    localparam int unsigned IN_DATA_W  = 64;
    localparam int unsigned OUT_DATA_W = 96;

    typedef struct packed {
        logic [13:0] min_rpm;
        logic [13:0] max_rpm;
        logic [7:0]  min_coolant;
        logic [19:0] holdoff_ticks;
        logic [15:0] duration_step;
    } cfg_t;

    typedef struct packed {
        kind_t       kind;
        logic [10:0] frame_id;
        logic [7:0]  byte_1;
        logic [7:0]  byte_2;
        logic [7:0]  byte_3;
        logic [7:0]  byte_4;
        logic [7:0]  byte_5;
        logic [7:0]  command;
    } item_t;

    // Values decoded from the frame bytes, before the identifier is looked at
    typedef struct packed {
        logic [13:0] rpm;
        logic [6:0]  throttle;
        logic [9:0]  quantity;
        logic [7:0]  speed;
        logic [7:0]  coolant;
        logic [7:0]  oil;
        logic [7:0]  outside;
        logic [6:0]  fuel;
        logic        low_fuel;
    } dec_t;

    typedef struct packed {
        logic        injector_on;
        logic [13:0] rpm_value;
        logic [6:0]  throttle_value;
        logic [9:0]  quantity_value;
        logic [7:0]  speed_value;
        logic [7:0]  coolant_value;
        logic [7:0]  oil_value;
        logic [7:0]  outside_value;
        logic [6:0]  fuel_value;
        logic        low_fuel;
        logic        enabled;
        logic [15:0] duration_value;
    } result_t;

endpackage

[rtl/core/gipc_cfg.sv]
module gipc_cfg (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [gipc_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [gipc_pkg::CFG_DATA_W-1:0]      cfg_data,
    output gipc_pkg::cfg_t                       cfg
);
    import gipc_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    // Register write decode; unknown indexes are dropped
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_MIN_RPM:       cfg_next.min_rpm       = cfg_data[13:0];
                CFG_MAX_RPM:       cfg_next.max_rpm       = cfg_data[13:0];
                CFG_MIN_COOLANT:   cfg_next.min_coolant   = cfg_data[7:0];
                CFG_HOLDOFF_TICKS: cfg_next.holdoff_ticks = cfg_data[19:0];
                CFG_DURATION_STEP: cfg_next.duration_step = cfg_data[15:0];
                default:           cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.min_rpm       <= 14'd500;
            cfg_reg.max_rpm       <= 14'd3500;
            cfg_reg.min_coolant   <= 8'd30;
            cfg_reg.holdoff_ticks <= 20'd40000;
            cfg_reg.duration_step <= 16'd10;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

[rtl/core/gipc_frame_decode.sv]
module gipc_frame_decode (
    input  gipc_pkg::item_t item,
    output gipc_pkg::dec_t  dec
);
    import gipc_pkg::*;

    logic [16:0]        thr_prod;
    logic [10:0]        qty_prod;
    logic [15:0]        spd_raw;
    logic [28:0]        spd_prod;
    logic [9:0]         cool_prod;
    logic [9:0]         oil_prod;
    logic signed [8:0]  out_diff;
    logic signed [8:0]  out_adj;
    logic signed [8:0]  out_half;

    // Scaling: constant divisions done by reciprocal multiply or shift
    always_comb
    begin
        // rpm = (b2 + 256*b3) / 4
        dec.rpm = {item.byte_3, item.byte_2[7:2]};

        // throttle = b5*4/10 = (2*b5)/5, via *410 >> 10 (exact for b5 < 256)
        thr_prod     = {9'd0, item.byte_5} * 17'd410;
        dec.throttle = thr_prod[16:10];

        // quantity = b1*25/10 = (5*b1)/2
        qty_prod     = {3'd0, item.byte_1} * 11'd5;
        dec.quantity = qty_prod[10:1];

        // speed = b3*129/100, /100 as *5243 >> 19 (exact below 43699)
        spd_raw   = {8'd0, item.byte_3} * 16'd129;
        spd_prod  = {13'd0, spd_raw} * 29'd5243;
        dec.speed = spd_prod[26:19];

        // temperatures: b*75/100 = (3*b)/4, offset 48, 8-bit wrap
        cool_prod   = {2'd0, item.byte_4} * 10'd3;
        oil_prod    = {2'd0, item.byte_3} * 10'd3;
        dec.coolant = cool_prod[9:2] - 8'd48;
        dec.oil     = oil_prod[9:2] - 8'd48;

        // outside = (b1 - 100)/2 truncated toward zero
        out_diff    = $signed({1'b0, item.byte_1}) - 9'sd100;
        out_adj     = out_diff + $signed({8'd0, out_diff[8]});
        out_half    = out_adj >>> 1;
        dec.outside = out_half[7:0];

        // fuel level and low-fuel flag from byte 2
        dec.fuel     = item.byte_2[6:0];
        dec.low_fuel = item.byte_2[7];
    end

endmodule

[rtl/core/gipc_core.sv]
module gipc_core (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             accept,
    input  gipc_pkg::item_t  item,
    input  gipc_pkg::cfg_t   cfg,
    output gipc_pkg::result_t result
);
    import gipc_pkg::*;

    typedef struct packed {
        logic [13:0] engine_rpm;
        logic [6:0]  throttle_pct;
        logic [9:0]  diesel_qty;
        logic [7:0]  road_speed;
        logic [7:0]  coolant;
        logic [7:0]  oil;
        logic [7:0]  outside;
        logic [6:0]  fuel_level;
        logic        low_fuel_flag;
        logic        lpg_enable;
        logic [15:0] pulse_length;
        logic        injector_active;
        logic [15:0] pulse_elapsed;
        logic [19:0] holdoff_elapsed;
    } state_t;

    // Everything cleared except the pulse length
    localparam state_t STATE_RESET = '{pulse_length: PULSE_LEN_RESET, default: '0};

    state_t state_reg;
    state_t state_next;
    dec_t   dec;
    logic   edge_qualified;

    gipc_frame_decode u_decode (
        .item (item),
        .dec  (dec)
    );

    // Gas may open only with enable, warm coolant and rpm in window
    assign edge_qualified = state_reg.lpg_enable
                         && (state_reg.coolant >= cfg.min_coolant)
                         && (state_reg.engine_rpm >= cfg.min_rpm)
                         && (state_reg.engine_rpm <= cfg.max_rpm);

    // Next state for the item on the input
    always_comb
    begin
        state_next = state_reg;
        unique case (item.kind)
            KIND_TICK:
            begin
                if (state_reg.pulse_elapsed != PULSE_MAX)
                begin
                    state_next.pulse_elapsed = state_reg.pulse_elapsed + 16'd1;
                end
                if (state_reg.holdoff_elapsed != HOLDOFF_MAX)
                begin
                    state_next.holdoff_elapsed = state_reg.holdoff_elapsed + 20'd1;
                end
                if (state_reg.injector_active
                    && (state_next.pulse_elapsed >= state_reg.pulse_length))
                begin
                    state_next.injector_active = 1'b0;
                end
            end
            KIND_FRAME:
            begin
                unique case (item.frame_id)
                    ID_ENGINE:
                    begin
                        state_next.engine_rpm   = dec.rpm;
                        state_next.throttle_pct = dec.throttle;
                        state_next.diesel_qty   = dec.quantity;
                    end
                    ID_SPEED:
                    begin
                        state_next.road_speed = dec.speed;
                    end
                    ID_TEMPS:
                    begin
                        state_next.coolant = dec.coolant;
                        state_next.oil     = dec.oil;
                        state_next.outside = dec.outside;
                    end
                    ID_FUEL:
                    begin
                        state_next.fuel_level    = dec.fuel;
                        state_next.low_fuel_flag = dec.low_fuel;
                    end
                    default:
                    begin
                        state_next = state_reg;
                    end
                endcase
            end
            KIND_EDGE:
            begin
                // Edges inside the holdoff window are ignored altogether
                if (state_reg.holdoff_elapsed > cfg.holdoff_ticks)
                begin
                    if (edge_qualified)
                    begin
                        state_next.injector_active = 1'b1;
                        state_next.pulse_elapsed   = 16'd0;
                    end
                    state_next.holdoff_elapsed = 20'd0;
                end
            end
            KIND_COMMAND:
            begin
                unique case (item.command)
                    CMD_ENABLE:  state_next.lpg_enable = 1'b1;
                    CMD_DISABLE: state_next.lpg_enable = 1'b0;
                    CMD_LONGER:
                        state_next.pulse_length = state_reg.pulse_length + cfg.duration_step;
                    CMD_SHORTER:
                        state_next.pulse_length = state_reg.pulse_length - cfg.duration_step;
                    default:     state_next = state_reg;
                endcase
            end
            default:
            begin
                state_next = state_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= STATE_RESET;
        end
        else if (accept)
        begin
            state_reg <= state_next;
        end
    end

    // Result shows the state after the item
    always_comb
    begin
        result.injector_on    = state_next.injector_active;
        result.rpm_value      = state_next.engine_rpm;
        result.throttle_value = state_next.throttle_pct;
        result.quantity_value = state_next.diesel_qty;
        result.speed_value    = state_next.road_speed;
        result.coolant_value  = state_next.coolant;
        result.oil_value      = state_next.oil;
        result.outside_value  = state_next.outside;
        result.fuel_value     = state_next.fuel_level;
        result.low_fuel       = state_next.low_fuel_flag;
        result.enabled        = state_next.lpg_enable;
        result.duration_value = state_next.pulse_length;
    end

endmodule

[rtl/core/gipc_out_buf.sv]
module gipc_out_buf (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  gipc_pkg::result_t  push_data,
    output logic               space,
    output logic               out_valid,
    input  logic               out_ready,
    output gipc_pkg::result_t  out_data
);
    import gipc_pkg::*;

    logic    main_valid_reg;
    logic    main_valid_next;
    result_t main_reg;
    result_t main_next;
    logic    skid_valid_reg;
    logic    skid_valid_next;
    result_t skid_reg;
    result_t skid_next;
    logic    take;

    assign space     = !skid_valid_reg;
    assign out_valid = main_valid_reg;
    assign out_data  = main_reg;
    assign take      = main_valid_reg && out_ready;

    // Output register plus skid stage, order kept
    always_comb
    begin
        main_valid_next = main_valid_reg;
        main_next       = main_reg;
        skid_valid_next = skid_valid_reg;
        skid_next       = skid_reg;
        if (take)
        begin
            if (skid_valid_reg)
            begin
                main_next       = skid_reg;
                skid_valid_next = 1'b0;
            end
            else
            begin
                main_valid_next = push;
                main_next       = push_data;
            end
        end
        else if (push)
        begin
            if (!main_valid_reg)
            begin
                main_valid_next = 1'b1;
                main_next       = push_data;
            end
            else
            begin
                skid_valid_next = 1'b1;
                skid_next       = push_data;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            main_valid_reg <= main_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        main_reg <= main_next;
        skid_reg <= skid_next;
    end

endmodule

[rtl/core/gas_injector_pulse_controller.sv]
// Gas injector pulse controller.
// Input stream (s_*): one item per transfer; s_tuser holds the kind
// (tick, CAN frame, diesel injector edge, command byte), s_tdata the
// frame identifier, data bytes 1 to 5 and the command byte.
// Output stream (m_*): one result per input item, giving injector drive,
// decoded engine values, enable and pulse length as they stand after it.
// Config channel (cfg_*): register index and data; always ready, write
// only while no item is in flight.
// Results are registered in the output buffer before they are presented.
// Throughput: one item per cycle unless stalled; the state update is a single
// pass of logic between the state registers, set by the tick/edge/frame update.
// Stall: a two-entry output buffer (output register and skid stage) holds
// results; s_tready drops only when both are full, and no result is lost.
// Reset: asynchronous, clears all engine values, counters, enable and the
// injector; pulse length returns to 100 ticks and the registers to their
// defaults (rpm 500..3500, coolant 30, holdoff 40000, step 10).
module gas_injector_pulse_controller (
    input  logic                                 clk,
    input  logic                                 rst_n,
    // Input stream
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    // [10:0] frame_id, [18:11] byte_1, [26:19] byte_2, [34:27] byte_3,
    // [42:35] byte_4, [50:43] byte_5, [58:51] command, [63:59] zero
    input  logic [gipc_pkg::IN_DATA_W-1:0]       s_tdata,
    // [1:0] kind
    input  logic [1:0]                           s_tuser,
    // Output stream
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    // [0] injector_on, [14:1] rpm_value, [21:15] throttle_value,
    // [31:22] quantity_value, [39:32] speed_value, [47:40] coolant_value,
    // [55:48] oil_value, [63:56] outside_value, [70:64] fuel_value,
    // [71] low_fuel, [72] enabled, [88:73] duration_value, [95:89] zero
    output logic [gipc_pkg::OUT_DATA_W-1:0]      m_tdata,
    // Configuration write channel
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [gipc_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [gipc_pkg::CFG_DATA_W-1:0]      cfg_data
);
    import gipc_pkg::*;

    cfg_t    cfg;
    item_t   item;
    result_t result;
    result_t out_result;
    logic    accept;
    logic    space;

    // Unpack input fields
    always_comb
    begin
        item.kind     = kind_t'(s_tuser);
        item.frame_id = s_tdata[10:0];
        item.byte_1   = s_tdata[18:11];
        item.byte_2   = s_tdata[26:19];
        item.byte_3   = s_tdata[34:27];
        item.byte_4   = s_tdata[42:35];
        item.byte_5   = s_tdata[50:43];
        item.command  = s_tdata[58:51];
    end

    assign s_tready = space;
    assign accept   = s_tvalid && space;

    gipc_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    gipc_core u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .accept (accept),
        .item   (item),
        .cfg    (cfg),
        .result (result)
    );

    gipc_out_buf u_out_buf (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (accept),
        .push_data (result),
        .space     (space),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (out_result)
    );

    // Pack result fields, lowest first
    assign m_tdata = {7'd0,
                      out_result.duration_value,
                      out_result.enabled,
                      out_result.low_fuel,
                      out_result.fuel_value,
                      out_result.outside_value,
                      out_result.oil_value,
                      out_result.coolant_value,
                      out_result.speed_value,
                      out_result.quantity_value,
                      out_result.throttle_value,
                      out_result.rpm_value,
                      out_result.injector_on};

endmodule
